// ----- rtl/core/cpu_subset_instruction_execute_defines.svh -----
// Assertion macros shared by the execute block.
`ifndef CPU_SUBSET_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CPU_SUBSET_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cse assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cse assertion failed");

`endif

// ----- rtl/core/cse_pkg.sv -----
// Types, flag positions and opcodes of the instruction execute block.
package cse_pkg;

  localparam int unsigned FLAG_W = 10;

  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_X = 4;
  localparam int unsigned FL_M = 5;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;
  localparam int unsigned FL_B = 8;
  localparam int unsigned FL_E = 9;

  localparam logic [15:0]       SP_RESET    = 16'h01ff;
  localparam logic [FLAG_W-1:0] FLAGS_RESET = 10'h230;

  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_XCE = 8'hfb;
  localparam logic [7:0] OP_PHK = 8'h4b;
  localparam logic [7:0] OP_PLB = 8'hab;
  localparam logic [7:0] OP_REP = 8'hc2;
  localparam logic [7:0] OP_SEP = 8'he2;
  localparam logic [7:0] OP_LDX = 8'ha2;
  localparam logic [7:0] OP_LDY = 8'ha0;
  localparam logic [7:0] OP_LDA = 8'ha9;
  localparam logic [7:0] OP_TXS = 8'h9a;
  localparam logic [7:0] OP_TCD = 8'h5b;
  localparam logic [7:0] OP_STY = 8'h8c;
  localparam logic [7:0] OP_STA = 8'h8d;
  localparam logic [7:0] OP_STX = 8'h8e;
  localparam logic [7:0] OP_STZ = 8'h9c;
  localparam logic [7:0] OP_DEX = 8'hca;
  localparam logic [7:0] OP_BNE = 8'hd0;
  localparam logic [7:0] OP_NOP = 8'hea;
  localparam logic [7:0] OP_JML = 8'h5c;
  localparam logic [7:0] OP_BIT = 8'h2c;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] pulled;
  } cse_instr_t;

  typedef struct packed {
    logic [15:0]       pc;
    logic [7:0]        pbank;
    logic [7:0]        dbank;
    logic [15:0]       dpage;
    logic [15:0]       acc;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       sp;
    logic [FLAG_W-1:0] flags;
  } cse_state_t;

  typedef struct packed {
    logic [15:0]       next_pc;
    logic [7:0]        program_bank;
    logic [15:0]       direct_page;
    logic [2:0]        cycle_count;
    logic [1:0]        write_count;
    logic [23:0]       write_address;
    logic [15:0]       write_data;
    logic [FLAG_W-1:0] status_flags;
    logic [15:0]       accumulator;
    logic [15:0]       index_x;
    logic [15:0]       index_y;
    logic [15:0]       stack_pointer;
  } cse_result_t;

endpackage

// ----- rtl/core/cse_if.sv -----
// Handshake channels of the execute block: instruction in, result out, config write.
interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand_first;
  logic [7:0] operand_second;
  logic [7:0] operand_third;
  logic [7:0] pulled_byte;

  modport source (output valid, output opcode, output operand_first,
                  output operand_second, output operand_third, output pulled_byte,
                  input ready);
  modport sink (input valid, input opcode, input operand_first,
                input operand_second, input operand_third, input pulled_byte,
                output ready);
endinterface

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  program_bank;
  logic [15:0] direct_page;
  logic [2:0]  cycle_count;
  logic [1:0]  write_count;
  logic [23:0] write_address;
  logic [15:0] write_data;
  logic [9:0]  status_flags;
  logic [15:0] accumulator;
  logic [15:0] index_x;
  logic [15:0] index_y;
  logic [15:0] stack_pointer;

  modport source (output valid, output next_pc, output program_bank,
                  output direct_page, output cycle_count, output write_count,
                  output write_address, output write_data, output status_flags,
                  output accumulator, output index_x, output index_y,
                  output stack_pointer, input ready);
  modport sink (input valid, input next_pc, input program_bank,
                input direct_page, input cycle_count, input write_count,
                input write_address, input write_data, input status_flags,
                input accumulator, input index_x, input index_y,
                input stack_pointer, output ready);
endinterface

interface cse_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/cse_exec.sv -----
// Combinational execute of one instruction against the register file.
module cse_exec
  import cse_pkg::*;
(
  input  cse_instr_t  instr_i,
  input  cse_state_t  state_i,
  output cse_state_t  state_o,
  output cse_result_t result_o
);

  cse_state_t        st;
  logic [2:0]        cycles;
  logic [1:0]        pcadd;
  logic [1:0]        wcount;
  logic [23:0]       waddr;
  logic [15:0]       wdata;
  logic              emu;
  logic              m8;
  logic              x8;
  logic              fix;
  logic              s8;
  logic [15:0]       sval;
  logic [FLAG_W-1:0] mask;
  logic [7:0]        lo;
  logic [15:0]       dec;

  always_comb begin
    st     = state_i;
    cycles = '0;
    pcadd  = '0;
    wcount = '0;
    waddr  = '0;
    wdata  = '0;
    emu    = state_i.flags[FL_E];
    m8     = state_i.flags[FL_M];
    x8     = state_i.flags[FL_X];
    fix    = 1'b0;
    s8     = 1'b0;
    sval   = '0;
    mask   = '0;
    lo     = state_i.x[7:0] - 8'd1;
    dec    = state_i.x - 16'd1;

    case (instr_i.opcode)
      OP_SEI: begin
        st.flags[FL_I] = 1'b1;
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_CLC: begin
        st.flags[FL_C] = 1'b0;
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_XCE: begin
        st.flags[FL_C] = emu;
        st.flags[FL_E] = state_i.flags[FL_C];
        fix = 1'b1;
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_PHK: begin
        wcount = 2'd1;
        waddr  = {8'h00, state_i.sp};
        wdata  = {8'h00, (emu ? 8'h00 : state_i.pbank)};
        st.sp  = state_i.sp - 16'd1;
        pcadd = 2'd1; cycles = 3'd3;
      end
      OP_PLB: begin
        st.dbank       = instr_i.pulled;
        st.flags[FL_Z] = (instr_i.pulled == 8'h00);
        st.flags[FL_N] = instr_i.pulled[7];
        st.sp          = state_i.sp + 16'd1;
        pcadd = 2'd1; cycles = 3'd4;
      end
      OP_REP, OP_SEP: begin
        // in emulation bit 4 of the mask lands on B; M and X are untouched
        if (emu) begin
          mask = {1'b0, instr_i.b1[4], instr_i.b1[7:6], 2'b00, instr_i.b1[3:0]};
        end else begin
          mask = {2'b00, instr_i.b1};
        end
        if (instr_i.opcode == OP_REP) begin
          st.flags = state_i.flags & ~mask;
        end else begin
          st.flags = state_i.flags | mask;
        end
        fix = 1'b1;
        pcadd = 2'd2; cycles = 3'd3;
      end
      OP_LDX: begin
        if (x8) begin
          st.x[7:0] = instr_i.b1;
          st.flags[FL_Z] = (instr_i.b1 == 8'h00);
          st.flags[FL_N] = instr_i.b1[7];
          pcadd = 2'd2; cycles = 3'd2;
        end else begin
          st.x = {instr_i.b2, instr_i.b1};
          st.flags[FL_Z] = ({instr_i.b2, instr_i.b1} == 16'h0000);
          st.flags[FL_N] = instr_i.b2[7];
          pcadd = 2'd3; cycles = 3'd3;
        end
      end
      OP_LDY: begin
        if (x8) begin
          st.y[7:0] = instr_i.b1;
          st.flags[FL_Z] = (instr_i.b1 == 8'h00);
          st.flags[FL_N] = instr_i.b1[7];
          pcadd = 2'd2; cycles = 3'd2;
        end else begin
          st.y = {instr_i.b2, instr_i.b1};
          st.flags[FL_Z] = ({instr_i.b2, instr_i.b1} == 16'h0000);
          st.flags[FL_N] = instr_i.b2[7];
          pcadd = 2'd3; cycles = 3'd3;
        end
      end
      OP_LDA: begin
        if (m8) begin
          st.acc[7:0] = instr_i.b1;
          st.flags[FL_Z] = (instr_i.b1 == 8'h00);
          st.flags[FL_N] = instr_i.b1[7];
          pcadd = 2'd2; cycles = 3'd2;
        end else begin
          st.acc = {instr_i.b2, instr_i.b1};
          st.flags[FL_Z] = ({instr_i.b2, instr_i.b1} == 16'h0000);
          st.flags[FL_N] = instr_i.b2[7];
          pcadd = 2'd3; cycles = 3'd3;
        end
      end
      OP_TXS: begin
        st.sp = emu ? {8'h01, state_i.x[7:0]} : state_i.x;
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_TCD: begin
        st.dpage       = state_i.acc;
        st.flags[FL_Z] = (state_i.acc == 16'h0000);
        st.flags[FL_N] = state_i.acc[15];
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_STY, OP_STA, OP_STX, OP_STZ: begin
        s8   = (instr_i.opcode == OP_STA || instr_i.opcode == OP_STZ) ? m8 : x8;
        sval = (instr_i.opcode == OP_STY) ? state_i.y :
               (instr_i.opcode == OP_STA) ? state_i.acc :
               (instr_i.opcode == OP_STX) ? state_i.x : 16'h0000;
        waddr  = {state_i.dbank, instr_i.b2, instr_i.b1};
        wcount = s8 ? 2'd1 : 2'd2;
        wdata  = s8 ? {8'h00, sval[7:0]} : sval;
        pcadd  = 2'd3;
        cycles = s8 ? 3'd4 : 3'd5;
      end
      OP_DEX: begin
        if (x8) begin
          st.x[7:0]      = lo;
          st.flags[FL_Z] = (lo == 8'h00);
          st.flags[FL_N] = lo[7];
        end else begin
          st.x           = dec;
          st.flags[FL_Z] = (dec == 16'h0000);
          st.flags[FL_N] = dec[15];
        end
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_BNE: begin
        if (!state_i.flags[FL_Z]) begin
          st.pc  = state_i.pc + 16'd2 + {{8{instr_i.b1[7]}}, instr_i.b1};
          cycles = 3'd3;
        end else begin
          pcadd = 2'd2; cycles = 3'd2;
        end
      end
      OP_NOP: begin
        pcadd = 2'd1; cycles = 3'd2;
      end
      OP_JML: begin
        st.pc    = {instr_i.b2, instr_i.b1};
        st.pbank = instr_i.b3;
        cycles   = 3'd4;
      end
      OP_BIT: begin
        pcadd  = 2'd3;
        cycles = m8 ? 3'd4 : 3'd5;
      end
      default: begin
        cycles = 3'd0;
      end
    endcase

    // keep sizes consistent after XCE, REP or SEP rewrite the flags
    if (fix) begin
      if (st.flags[FL_E]) begin
        st.flags[FL_M] = 1'b1;
        st.flags[FL_X] = 1'b1;
      end
      if (st.flags[FL_X]) begin
        st.x[15:8] = 8'h00;
        st.y[15:8] = 8'h00;
      end
    end

    st.pc = st.pc + {14'd0, pcadd};
  end

  assign state_o = st;

  assign result_o.next_pc       = st.pc;
  assign result_o.program_bank  = st.pbank;
  assign result_o.direct_page   = st.dpage;
  assign result_o.cycle_count   = cycles;
  assign result_o.write_count   = wcount;
  assign result_o.write_address = waddr;
  assign result_o.write_data    = wdata;
  assign result_o.status_flags  = st.flags;
  assign result_o.accumulator   = st.acc;
  assign result_o.index_x       = st.x;
  assign result_o.index_y       = st.y;
  assign result_o.stack_pointer = st.sp;

endmodule

// ----- rtl/core/cse_out_reg.sv -----
// Result register that holds one result word until the consumer takes it.
module cse_out_reg
  import cse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  cse_result_t   result_i,
  output logic          can_load,
  cse_out_if.source     out_ch
);

  logic        out_vld_r;
  cse_result_t res_r;

  assign can_load = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (can_load) begin
      out_vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result_i;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.next_pc       = res_r.next_pc;
  assign out_ch.program_bank  = res_r.program_bank;
  assign out_ch.direct_page   = res_r.direct_page;
  assign out_ch.cycle_count   = res_r.cycle_count;
  assign out_ch.write_count   = res_r.write_count;
  assign out_ch.write_address = res_r.write_address;
  assign out_ch.write_data    = res_r.write_data;
  assign out_ch.status_flags  = res_r.status_flags;
  assign out_ch.accumulator   = res_r.accumulator;
  assign out_ch.index_x       = res_r.index_x;
  assign out_ch.index_y       = res_r.index_y;
  assign out_ch.stack_pointer = res_r.stack_pointer;

endmodule

// ----- rtl/core/cpu_subset_instruction_execute.sv -----
// Top level of the instruction execute block: input stage, register file, execute, result.
`include "cpu_subset_instruction_execute_defines.svh"

// Executes one pre-fetched instruction word per clock while the consumer
// keeps ready high. An accepted word is held in the input register; the
// execute logic then reads it together with the register file (PC, banks,
// direct page, A, X, Y, SP and the ten flags), updates the register file
// and loads the result register once that register can take it, so each
// result word passes through the input register and then the result
// register. The rate is set by the combinational loop from the register
// file through the execute logic back into the register file.
// The result register stalls the execute stage only while the consumer
// holds ready low. The reset vector comes from the configuration channel
// (always ready); until the first instruction after reset executes, the PC
// follows that register, so a vector written after reset still applies.
// Unknown opcodes change nothing and report a cycle count of zero.
module cpu_subset_instruction_execute
  import cse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cse_in_if.sink     in_ch,
  cse_out_if.source  out_ch,
  cse_cfg_if.sink    cfg_ch
);

  logic        in_vld_r;
  cse_instr_t  instr_r;
  cse_state_t  state_r;
  cse_state_t  state_nxt;
  cse_state_t  exec_state;
  cse_result_t exec_res;
  logic [15:0] rst_vec_r;
  logic        vec_pend_r;
  logic        can_load;
  logic        exec_fire;

  // config port never stalls; writes must arrive only while idle, which the block itself does not enforce
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_vec_r <= 16'h0000;
    end else if (cfg_ch.valid) begin
      rst_vec_r <= cfg_ch.data;
    end
  end

  // execute whenever a word is held and the result register can take it
  assign exec_fire   = in_vld_r && can_load;
  assign in_ch.ready = !in_vld_r || exec_fire;

  // input stage: advance on every handshake slot, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      instr_r.opcode <= in_ch.opcode;
      instr_r.b1     <= in_ch.operand_first;
      instr_r.b2     <= in_ch.operand_second;
      instr_r.b3     <= in_ch.operand_third;
      instr_r.pulled <= in_ch.pulled_byte;
    end
  end

  // substitute the reset vector for the PC until the first instruction runs
  always_comb begin
    exec_state = state_r;
    if (vec_pend_r) begin
      exec_state.pc = rst_vec_r;
    end
  end

  cse_exec u_exec (
    .instr_i  (instr_r),
    .state_i  (exec_state),
    .state_o  (state_nxt),
    .result_o (exec_res)
  );

  // register file: commit the executed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pc    <= 16'h0000;
      state_r.pbank <= 8'h00;
      state_r.dbank <= 8'h00;
      state_r.dpage <= 16'h0000;
      state_r.acc   <= 16'h0000;
      state_r.x     <= 16'h0000;
      state_r.y     <= 16'h0000;
      state_r.sp    <= SP_RESET;
      state_r.flags <= FLAGS_RESET;
      vec_pend_r    <= 1'b1;
    end else if (exec_fire) begin
      state_r    <= state_nxt;
      vec_pend_r <= 1'b0;
    end
  end

  cse_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (exec_fire),
    .result_i (exec_res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  `CSE_ASSERT_NXT(a_fire_fills_out, exec_fire, out_ch.valid)
  `CSE_ASSERT_NXT(a_vector_consumed, exec_fire, !vec_pend_r)
  `CSE_ASSERT_IMP(a_unknown_no_write, out_ch.valid && out_ch.cycle_count == 3'd0, out_ch.write_count == 2'd0)
  `CSE_ASSERT_IMP(a_x8_high_clear, state_r.flags[FL_X], state_r.x[15:8] == 8'h00 && state_r.y[15:8] == 8'h00)
  `CSE_ASSERT_IMP(a_emu_sizes, state_r.flags[FL_E], state_r.flags[FL_M] && state_r.flags[FL_X])

endmodule
